// ===== rtl/rrbb_pkg.sv =====
`default_nettype none
package rrbb_pkg;

	// field widths and fixed point format
	localparam int COORD_W = 24;
	localparam int FRAC_BITS = 8;
	localparam int ANG_W = 16;
	localparam int SIN_W = 18;
	localparam int SIN_LAT = 6;
	localparam int PROD_W = COORD_W + SIN_W;
	localparam int EXT_W = PROD_W + 1;
	localparam int POS_W = COORD_W + 4;
	localparam int DIV_N = POS_W + FRAC_BITS;
	localparam int NUM_W = DIV_N + 2;
	localparam int NUM_LANES = 4;

	// quarter-wave sine polynomial, Q30
	localparam logic [31:0] POLY_A = 32'd1686629713;
	localparam logic [31:0] POLY_B = 32'd688904866;
	localparam logic [31:0] POLY_C = 32'd76016977;

	// register indexes
	typedef enum logic [1:0] {
		REG_OFF_X = 2'd0,
		REG_OFF_Y = 2'd1,
		REG_CELL_SIZE = 2'd2
	} reg_idx_t;

	// one division in flight through the cell chain
	typedef struct packed {
		logic grid;
		logic neg;
		logic [DIV_N-1:0] num;
		logic [DIV_N-1:0] quo;
		logic [COORD_W-1:0] rem;
		logic [COORD_W-1:0] dvs;
	} div_t;

	// signed position: optional grid offset and scale, then sign-magnitude
	function automatic div_t div_prep_s(input logic [POS_W-1:0] pos,
			input logic [COORD_W-1:0] off, input logic grid, input logic [COORD_W-1:0] dvs);
		logic [NUM_W-1:0] n;
		logic [NUM_W-1:0] mag;
		div_t r;
		if (grid) begin
			n = ({{(NUM_W-POS_W){pos[POS_W-1]}}, pos}
				- {{(NUM_W-COORD_W){off[COORD_W-1]}}, off}) << FRAC_BITS;
		end else begin
			n = {{(NUM_W-POS_W){pos[POS_W-1]}}, pos};
		end
		mag = n[NUM_W-1] ? (~n + 1'b1) : n;
		r.grid = grid;
		r.neg = n[NUM_W-1];
		r.num = mag[DIV_N-1:0];
		r.quo = '0;
		r.rem = '0;
		r.dvs = dvs;
		return r;
	endfunction

	// unsigned extent
	function automatic div_t div_prep_u(input logic [POS_W-1:0] sz, input logic grid,
			input logic [COORD_W-1:0] dvs);
		div_t r;
		r.grid = grid;
		r.neg = 1'b0;
		r.num = grid ? ({{(DIV_N-POS_W){1'b0}}, sz} << FRAC_BITS)
			: {{(DIV_N-POS_W){1'b0}}, sz};
		r.quo = '0;
		r.rem = '0;
		r.dvs = dvs;
		return r;
	endfunction

	// floor quotient, saturated to the signed field
	function automatic logic [COORD_W-1:0] fin_s(input div_t d);
		logic signed [NUM_W-1:0] v;
		logic [NUM_W-1:0] u;
		logic [COORD_W-1:0] r;
		u = {2'b00, d.quo} + {{(NUM_W-1){1'b0}}, (d.neg && (d.rem != '0))};
		v = d.neg ? signed'(~u + 1'b1) : signed'(u);
		if (v > signed'(NUM_W'((1 << (COORD_W-1)) - 1))) begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v < -signed'(NUM_W'(1 << (COORD_W-1)))) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	// quotient saturated to the unsigned field
	function automatic logic [COORD_W-1:0] fin_u(input div_t d);
		return (d.quo[DIV_N-1:COORD_W] != '0) ? {COORD_W{1'b1}} : d.quo[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rrbb_sine.sv =====
`default_nettype none
module rrbb_sine import rrbb_pkg::*; (
	input wire logic clk,
	input wire logic [ANG_W-1:0] angle,
	output logic [SIN_W-1:0] mag
);

	logic [14:0] z_s1, z_s2, z_s3, z_s4;
	logic [30:0] z2_s2, z2_s3;
	logic [31:0] p_s3;
	logic [31:0] m_s4;
	logic [31:0] n_s5;
	logic [SIN_W-1:0] mag_s6;
	logic [14:0] z_fold;
	logic [61:0] pc, pm, pn;
	logic [30:0] z30;

	// fold the angle into one quarter wave
	always_comb begin
		z_fold = angle[ANG_W-2] ? (15'd16384 - {1'b0, angle[ANG_W-3:0]})
			: {1'b0, angle[ANG_W-3:0]};
		pc = 62'(POLY_C) * 62'(z2_s2);
		pm = 62'(POLY_B - p_s3) * 62'(z2_s3);
		z30 = {z_s4, 16'd0};
		pn = 62'(POLY_A - m_s4) * 62'(z30);
	end

	// at most one multiply per stage
	always_ff @(posedge clk) begin
		z_s1 <= z_fold;
		z_s2 <= z_s1;
		z2_s2 <= {29'(z_s1) * 29'(z_s1), 2'b00};
		z_s3 <= z_s2;
		z2_s3 <= z2_s2;
		p_s3 <= pc[61:30];
		z_s4 <= z_s3;
		m_s4 <= pm[61:30];
		n_s5 <= pn[61:30];
		mag_s6 <= SIN_W'((33'(n_s5) + 33'd8192) >> 14);
	end

	assign mag = mag_s6;

endmodule
`default_nettype wire

// ===== rtl/rrbb_div_cell.sv =====
`default_nettype none
module rrbb_div_cell import rrbb_pkg::*; (
	input wire logic clk,
	input wire div_t d_in,
	output div_t d_out
);

	logic [COORD_W:0] trial, diff;
	logic ge;
	div_t nxt;

	// one restoring step: bring down the next numerator bit
	always_comb begin
		trial = {d_in.rem, d_in.num[DIV_N-1]};
		diff = trial - {1'b0, d_in.dvs};
		ge = trial >= {1'b0, d_in.dvs};
		nxt = d_in;
		nxt.num = {d_in.num[DIV_N-2:0], 1'b0};
		nxt.quo = {d_in.quo[DIV_N-2:0], ge};
		nxt.rem = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		d_out <= nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/rotated_rect_bounding_box.sv =====
`default_nettype none
// Throughput: one rectangle per cycle; busy is always low.
// Latency is set by the 6-stage sine pipeline, 4 extent stages and a chain of
// 36 restoring divider cells, one quotient bit per cell, plus the output register.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset clears the valid line and sets the registers to offset 0, cell size 1.0.
module rotated_rect_bounding_box import rrbb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	output logic done,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [COORD_W-1:0] cfg_data,
	input wire logic [COORD_W-1:0] center_x,
	input wire logic [COORD_W-1:0] center_y,
	input wire logic [COORD_W-1:0] size_x,
	input wire logic [COORD_W-1:0] size_y,
	input wire logic [ANG_W-1:0] rotation_angle,
	input wire logic grid_mode,
	output logic [COORD_W-1:0] box_x,
	output logic [COORD_W-1:0] box_y,
	output logic [COORD_W-1:0] box_width,
	output logic [COORD_W-1:0] box_height
);

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic grid;
	} item_t;

	logic [COORD_W-1:0] off_x_q, off_y_q, cell_size_q;
	item_t item_dly_q [SIN_LAT];
	logic [SIN_LAT-1:0] vld_dly_q;
	logic [SIN_W-1:0] sin_mag, cos_mag;
	logic [ANG_W-1:0] cos_angle;
	item_t item_s7;
	logic vld_s7, vld_s8, vld_s9, vld_s10;
	logic [PROD_W-1:0] wc_s7, hs_s7, ws_s7, hc_s7;
	logic [EXT_W-1:0] ex_s8, ey_s8;
	logic [COORD_W-1:0] cx_s8, cy_s8;
	logic grid_s8, grid_s9;
	logic [POS_W-1:0] bx_s9, by_s9, bw_s9, bh_s9;
	logic [COORD_W-1:0] dvs;
	div_t div_s10 [NUM_LANES];
	div_t div_c [NUM_LANES][DIV_N+1];
	logic [DIV_N-1:0] vld_div_q;
	logic done_q;
	logic [COORD_W-1:0] box_x_q, box_y_q, box_w_q, box_h_q;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			cell_size_q <= COORD_W'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFF_X: off_x_q <= cfg_data;
				REG_OFF_Y: off_y_q <= cfg_data;
				REG_CELL_SIZE: cell_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sine and cosine magnitudes
	assign cos_angle = rotation_angle + ANG_W'(1 << (ANG_W-2));
	rrbb_sine u_sin (.clk(clk), .angle(rotation_angle), .mag(sin_mag));
	rrbb_sine u_cos (.clk(clk), .angle(cos_angle), .mag(cos_mag));

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dly_q <= '0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_div_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_dly_q <= {vld_dly_q[SIN_LAT-2:0], start};
			vld_s7 <= vld_dly_q[SIN_LAT-1];
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_div_q <= {vld_div_q[DIV_N-2:0], vld_s10};
			done_q <= vld_div_q[DIV_N-1];
		end
	end

	// item fields ride alongside the sine pipeline
	always_ff @(posedge clk) begin
		item_dly_q[0] <= '{cx: center_x, cy: center_y, w: size_x, h: size_y, grid: grid_mode};
		for (int i = 1; i < SIN_LAT; i++) begin
			item_dly_q[i] <= item_dly_q[i-1];
		end
	end

	// corner projections and extents
	always_comb begin
		dvs = !grid_s9 ? COORD_W'(1) : ((cell_size_q == '0) ? COORD_W'(1) : cell_size_q);
	end

	always_ff @(posedge clk) begin
		item_s7 <= item_dly_q[SIN_LAT-1];
		wc_s7 <= PROD_W'(item_dly_q[SIN_LAT-1].w) * PROD_W'(cos_mag);
		hs_s7 <= PROD_W'(item_dly_q[SIN_LAT-1].h) * PROD_W'(sin_mag);
		ws_s7 <= PROD_W'(item_dly_q[SIN_LAT-1].w) * PROD_W'(sin_mag);
		hc_s7 <= PROD_W'(item_dly_q[SIN_LAT-1].h) * PROD_W'(cos_mag);
		ex_s8 <= EXT_W'(wc_s7) + EXT_W'(hs_s7);
		ey_s8 <= EXT_W'(ws_s7) + EXT_W'(hc_s7);
		cx_s8 <= item_s7.cx;
		cy_s8 <= item_s7.cy;
		grid_s8 <= item_s7.grid;
		bx_s9 <= {{(POS_W-COORD_W){cx_s8[COORD_W-1]}}, cx_s8}
			- POS_W'((EXT_W'(ex_s8) + EXT_W'(1 << 16)) >> 17);
		by_s9 <= {{(POS_W-COORD_W){cy_s8[COORD_W-1]}}, cy_s8}
			- POS_W'((EXT_W'(ey_s8) + EXT_W'(1 << 16)) >> 17);
		bw_s9 <= POS_W'((EXT_W'(ex_s8) + EXT_W'(1 << 15)) >> 16);
		bh_s9 <= POS_W'((EXT_W'(ey_s8) + EXT_W'(1 << 15)) >> 16);
		grid_s9 <= grid_s8;
		div_s10[0] <= div_prep_s(bx_s9, off_x_q, grid_s9, dvs);
		div_s10[1] <= div_prep_s(by_s9, off_y_q, grid_s9, dvs);
		div_s10[2] <= div_prep_u(bw_s9, grid_s9, dvs);
		div_s10[3] <= div_prep_u(bh_s9, grid_s9, dvs);
	end

	// divider cell chains, one per output field
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		assign div_c[l][0] = div_s10[l];
		for (genvar k = 0; k < DIV_N; k++) begin : g_cell
			rrbb_div_cell u_cell (.clk(clk), .d_in(div_c[l][k]), .d_out(div_c[l][k+1]));
		end
	end

	// floor, sign and saturation
	always_ff @(posedge clk) begin
		box_x_q <= fin_s(div_c[0][DIV_N]);
		box_y_q <= fin_s(div_c[1][DIV_N]);
		box_w_q <= fin_u(div_c[2][DIV_N]);
		box_h_q <= fin_u(div_c[3][DIV_N]);
	end

	assign done = done_q;
	assign box_x = box_x_q;
	assign box_y = box_y_q;
	assign box_width = box_w_q;
	assign box_height = box_h_q;

`ifndef SYNTH
	a_dvs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 |-> (div_s10[0].dvs != '0 && div_s10[2].dvs != '0))
		else $error("divisor zero entering divider chain");

	a_world_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_div_q[DIV_N-1] && !div_c[0][DIV_N].grid) |->
		(div_c[0][DIV_N].rem == '0 && div_c[3][DIV_N].rem == '0))
		else $error("world mode division left a remainder");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_div_q[DIV_N-1] |=> done)
		else $error("divider output not delivered");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_rotated_rect_bounding_box.sv =====
`default_nettype none
module tb_rotated_rect_bounding_box;
	import rrbb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 60;
	localparam longint SMAX = (64'sd1 <<< (COORD_W-1)) - 1;
	localparam longint SMIN = -SMAX - 1;
	localparam longint UMAX = (64'sd1 <<< COORD_W) - 1;

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [ANG_W-1:0] ang;
		logic grid;
	} rect_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic [COORD_W-1:0] center_x = '0, center_y = '0, size_x = '0, size_y = '0;
	logic [ANG_W-1:0] rotation_angle = '0;
	logic grid_mode = 1'b0;
	logic busy, done;
	logic [COORD_W-1:0] box_x, box_y, box_width, box_height;

	// predictor copy of the registers
	longint off_x = 0, off_y = 0, cell_sz = 256;

	rect_t pending_rects[$];
	box_t expected_boxes[$];
	int errors = 0;
	int rects_sent = 0;
	int boxes_checked = 0;
	int burst_left = 0;
	int gap_left = 0;

	rotated_rect_bounding_box dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("FAIL rotated_rect_bounding_box");
		$finish;
	end

	// quarter-wave polynomial sine, Q1.16
	function automatic longint sine_q16(input logic [ANG_W-1:0] a);
		logic [1:0] quad;
		longint unsigned z30, z2, t;
		quad = a[15:14];
		z30 = (quad[0] ? (64'd16384 - a[13:0]) : 64'(a[13:0])) << 16;
		z2 = (z30 * z30) >> 30;
		t = 64'(POLY_B) - ((64'(POLY_C) * z2) >> 30);
		t = 64'(POLY_A) - ((t * z2) >> 30);
		t = (t * z30) >> 30;
		t = (t + 8192) >> 14;
		return quad[1] ? -longint'(t) : longint'(t);
	endfunction

	function automatic longint floor_quot(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_s(input longint v);
		return (v > SMAX) ? COORD_W'(SMAX) : ((v < SMIN) ? COORD_W'(SMIN) : COORD_W'(v));
	endfunction

	function automatic logic [COORD_W-1:0] clamp_u(input longint v);
		return (v > UMAX) ? COORD_W'(UMAX) : ((v < 0) ? '0 : COORD_W'(v));
	endfunction

	function automatic box_t bounding_box(input rect_t r);
		longint cx, cy, w, h, s, c, ex, ey, bx, by, bw, bh, d;
		box_t b;
		cx = longint'(signed'(r.cx));
		cy = longint'(signed'(r.cy));
		w = longint'(r.sx);
		h = longint'(r.sy);
		s = sine_q16(r.ang);
		c = sine_q16(r.ang + 16'd16384);
		if (s < 0) s = -s;
		if (c < 0) c = -c;
		ex = w * c + h * s;
		ey = w * s + h * c;
		bx = cx - ((ex + 65536) >>> 17);
		by = cy - ((ey + 65536) >>> 17);
		bw = (ex + 32768) >>> 16;
		bh = (ey + 32768) >>> 16;
		if (r.grid) begin
			d = (cell_sz == 0) ? 1 : cell_sz;
			bx = floor_quot((bx - off_x) * 256, d);
			by = floor_quot((by - off_y) * 256, d);
			bw = (bw * 256) / d;
			bh = (bh * 256) / d;
		end
		b.x = clamp_s(bx);
		b.y = clamp_s(by);
		b.w = clamp_u(bw);
		b.h = clamp_u(bh);
		return b;
	endfunction

	function automatic rect_t random_rect();
		rect_t r;
		r.cx = COORD_W'($urandom);
		r.cy = COORD_W'($urandom);
		r.sx = COORD_W'($urandom);
		r.sy = COORD_W'($urandom);
		r.ang = ANG_W'($urandom);
		r.grid = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: begin
				r.sx = COORD_W'($urandom_range(0, 4096));
				r.sy = COORD_W'($urandom_range(0, 4096));
			end
			1: r.ang = 16'(16384 * $urandom_range(0, 3)) + 16'($urandom_range(0, 2)) - 16'd1;
			2: begin r.cx = {1'b1, 23'd0}; r.cy = {1'b0, {23{1'b1}}}; end
			default: ;
		endcase
		return r;
	endfunction

	// driver: bursts and gaps, presents the next transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_boxes.push_back(bounding_box(pending_rects.pop_front()));
				rects_sent++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_rects.size() > 0) begin
				rect_t r;
				r = pending_rects[0];
				center_x <= r.cx;
				center_y <= r.cy;
				size_x <= r.sx;
				size_y <= r.sy;
				rotation_angle <= r.ang;
				grid_mode <= r.grid;
				start <= 1'b1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each done transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_boxes.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h w=%h h=%h", $time,
					box_x, box_y, box_width, box_height);
				errors++;
			end else begin
				box_t e;
				e = expected_boxes.pop_front();
				if (box_x !== e.x) begin
					$display("%0t: box_x expected %h actual %h", $time, e.x, box_x);
					errors++;
				end
				if (box_y !== e.y) begin
					$display("%0t: box_y expected %h actual %h", $time, e.y, box_y);
					errors++;
				end
				if (box_width !== e.w) begin
					$display("%0t: box_width expected %h actual %h", $time, e.w, box_width);
					errors++;
				end
				if (box_height !== e.h) begin
					$display("%0t: box_height expected %h actual %h", $time, e.h, box_height);
					errors++;
				end
				boxes_checked++;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [COORD_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_OFF_X: off_x = longint'(signed'(v));
			REG_OFF_Y: off_y = longint'(signed'(v));
			default: cell_sz = longint'(v);
		endcase
	endtask

	task automatic write_stray(input logic [COORD_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 2'd3;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_rects.size() > 0 || expected_boxes.size() > 0 || start)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_rect(input logic [COORD_W-1:0] cx, cy, sx, sy,
			input logic [ANG_W-1:0] ang, input logic grid);
		rect_t r;
		r = '{cx, cy, sx, sy, ang, grid};
		pending_rects.push_back(r);
	endtask

	task automatic add_random(input int n);
		repeat (n) pending_rects.push_back(random_rect());
	endtask

	initial begin
		logic [COORD_W-1:0] cells[6];
		cells = '{24'd256, 24'd1, 24'hFFFFFF, 24'd0, 24'd100, 24'd4096};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, cardinal angles, grid on and off at reset config
		add_rect('0, '0, '0, '0, '0, 1'b0);
		add_rect(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 1'b0);
		add_rect(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF, 16'd8192, 1'b0);
		add_rect(24'h000100, 24'hFFFF00, 24'h000A00, 24'h000300, 16'd16384, 1'b0);
		add_rect(24'h000100, 24'hFFFF00, 24'h000A00, 24'h000300, 16'd32768, 1'b1);
		add_rect(24'h000100, 24'hFFFF00, 24'h000A00, 24'h000300, 16'd49152, 1'b1);
		add_rect(24'h123456, 24'h654321, 24'h000001, 24'h000001, 16'hFFFF, 1'b1);
		add_rect(24'h800000, 24'h800000, 24'hFFFFFF, 24'h000000, 16'd16383, 1'b1);
		add_rect(24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 16'd1, 1'b1);
		add_rect(24'hFFFFFF, 24'h000001, 24'h555555, 24'hAAAAAA, 16'h5555, 1'b0);
		add_rect(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 16'hAAAA, 1'b1);
		drain();

		// phases across register settings, extremes included
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_CELL_SIZE, (p < 6) ? cells[p] : 24'($urandom));
			write_reg(REG_OFF_X, (p == 1) ? 24'h800000 : (p == 2) ? 24'h7FFFFF : 24'($urandom));
			write_reg(REG_OFF_Y, (p == 1) ? 24'h7FFFFF : (p == 2) ? 24'h800000 : 24'($urandom));
			write_stray(24'($urandom));
			if (p < 6) begin
				add_rect(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd8192, 1'b1);
				add_rect(24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 16'd0, 1'b1);
			end
			add_random(100);
			drain();
		end

		$display("Covered %0d rectangles over 8 register settings; %0d boxes checked.",
			rects_sent, boxes_checked);
		if (errors == 0) begin
			$display("PASS rotated_rect_bounding_box");
		end else begin
			$display("FAIL rotated_rect_bounding_box");
		end
		$finish;
	end
endmodule
`default_nettype wire
